[src/fdn_pkg.sv]
// Shared types, constants and helpers for the eight-line feedback delay network.
// No dependencies; imported by every other file in this block except fdn_delay_ram.
`default_nettype none

package fdn_pkg;

    localparam int NLINES       = 8;
    localparam int LINE_W       = 3;
    localparam int LINE_DEPTH   = 4096;
    localparam int PTR_W        = 12;
    localparam int FILL_W       = 13;
    localparam int SAMPLE_BITS  = 24;
    localparam int ADDR_W       = LINE_W + PTR_W;
    localparam int MIX_W        = 27;
    localparam int Q16_ONE      = 65536;
    localparam int HAD_NORM     = 23170;
    localparam int GAIN_CEIL    = 65529;
    localparam int BYPASS_BELOW = 66;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [LINE_W-1:0]             line_t;
    typedef logic [PTR_W-1:0]              ptr_t;
    typedef logic [FILL_W-1:0]             fill_t;
    typedef logic signed [MIX_W-1:0]       mix_t;
    typedef logic [16:0]                   q16_t;

    typedef enum logic [2:0] {
        CFG_WET      = 3'd0,
        CFG_DAMP     = 3'd1,
        CFG_GAIN_LO  = 3'd2,
        CFG_GAIN_HI  = 3'd3,
        CFG_LEN_LO   = 3'd4,
        CFG_LEN_HI   = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_MIX,
        ST_FEED,
        ST_DRAIN,
        ST_BLEND,
        ST_DONE
    } fdn_state_t;

    // Feedback write request from the damping pipe
    typedef struct packed {
        logic    valid;
        line_t   line;
        sample_t fb;
    } fb_wr_t;

    function automatic sample_t sat32(input logic signed [31:0] v);
        sample_t r;
        if (v > 32'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -32'sd8388608)
            r = 24'sh800000;
        else
            r = v[SAMPLE_BITS-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[src/fdn_in_if.sv]
// Input sample channel: valid/ready plus dry sample and restart flag.
// Depends on fdn_pkg.
`default_nettype none

interface fdn_in_if import fdn_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t dry_sample;
    logic    restart;

    modport source (output valid, dry_sample, restart, input ready);
    modport sink   (input valid, dry_sample, restart, output ready);
endinterface

`default_nettype wire

[src/fdn_out_if.sv]
// Output sample channel: valid/ready plus blended sample.
// Depends on fdn_pkg.
`default_nettype none

interface fdn_out_if import fdn_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t mixed_sample;

    modport source (output valid, mixed_sample, input ready);
    modport sink   (input valid, mixed_sample, output ready);
endinterface

`default_nettype wire

[src/fdn_delay_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module fdn_delay_ram #(
    parameter  int DEPTH = 32768,
    parameter  int WIDTH = 24,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/fdn_feedback_pipe.sv]
// Per-line feedback path: Hadamard scale, line gain, one-pole damping.
// Three multiply stages, one line per cycle. Depends on fdn_pkg.
`default_nettype none

module fdn_feedback_pipe import fdn_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        clear,
    input  wire logic        in_valid,
    input  wire line_t       in_line,
    input  wire mix_t        in_mix,
    input  wire logic [15:0] in_gain,
    input  wire q16_t        dc,
    output fb_wr_t           wr
);

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    line_t              s1_line_reg, s2_line_reg, s3_line_reg;
    logic [15:0]        s1_gain_reg;
    logic signed [42:0] p1_reg;
    logic signed [43:0] p2_reg;
    logic signed [46:0] p3_reg;
    sample_t            d3_reg;
    sample_t            damp_reg [NLINES];

    logic signed [42:0] p1_next;
    logic signed [42:0] r1;
    logic signed [26:0] m1;
    logic signed [43:0] p2_next;
    logic signed [43:0] r2;
    logic signed [27:0] m2;
    logic signed [28:0] diff;
    logic signed [46:0] p3_next;
    logic signed [46:0] r3;
    logic signed [31:0] t4;
    sample_t            fb;
    sample_t            d_cur;

    always_comb
    begin
        p1_next = in_mix * $signed(16'sd23170);
        r1      = p1_reg + 43'sd32768;
        m1      = r1[42:16];
        p2_next = m1 * $signed({1'b0, s1_gain_reg});
        r2      = p2_reg + 44'sd32768;
        m2      = r2[43:16];
        d_cur   = damp_reg[s2_line_reg];
        diff    = 29'(m2) - 29'(d_cur);
        p3_next = diff * $signed({1'b0, dc});
        r3      = p3_reg + 47'sd32768;
        t4      = 32'(d3_reg) + 32'($signed(r3[46:16]));
        fb      = sat32(t4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            for (int i = 0; i < NLINES; i++)
            begin
                damp_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (clear)
            begin
                for (int i = 0; i < NLINES; i++)
                begin
                    damp_reg[i] <= '0;
                end
            end
            else if (s3_valid_reg)
            begin
                damp_reg[s3_line_reg] <= fb;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_line_reg <= in_line;
        s1_gain_reg <= in_gain;
        p1_reg      <= p1_next;
        s2_line_reg <= s1_line_reg;
        p2_reg      <= p2_next;
        s3_line_reg <= s2_line_reg;
        p3_reg      <= p3_next;
        d3_reg      <= d_cur;
    end

    assign wr.valid = s3_valid_reg;
    assign wr.line  = s3_line_reg;
    assign wr.fb    = fb;

endmodule

`default_nettype wire

[src/fdn_reverb_eight_line_unit.sv]
// Eight-line feedback delay network reverb, top level.
// One sample in flight: the next sample is accepted once the result has moved
// into the output register. The pointer table has one read index, so the eight
// head reads and the eight feedback writes through a 3-stage pipe run in turn.
// Near-zero wet level bypasses the network, going from accept straight to done.
// Async active-low reset clears control, pointers, fill counts, damping; config takes its defaults.
`default_nettype none

module fdn_reverb_eight_line_unit import fdn_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    fdn_in_if.sink           samples,
    fdn_out_if.source        results,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam logic [63:0] LEN_RESET = 64'd1152939097061330944;

    fdn_state_t state_reg, state_next;
    line_t      cnt_reg;

    q16_t        wet_reg, dampc_reg;
    logic [63:0] gain_lo_reg, gain_hi_reg, len_lo_reg, len_hi_reg;

    ptr_t  ptr_reg  [NLINES];
    fill_t fill_reg [NLINES];

    sample_t            dry_reg;
    sample_t            head_reg [NLINES];
    mix_t               mix_reg  [NLINES];
    logic signed [22:0] quarter_reg;
    logic signed [24:0] wet_val_reg;
    logic signed [42:0] prod_a_reg;
    sample_t            result_reg;
    logic               out_valid_reg;
    sample_t            out_data_reg;

    logic  rd_pend_reg, rd_hit_reg;
    line_t rd_line_reg;

    q16_t        wl_eff, dc_eff, one_minus;
    logic        accept, bypass;
    line_t       sel_line;
    ptr_t        ptr_sel;
    fill_t       fill_sel;
    fb_wr_t      wr;
    logic [15:0] gain_raw, gain_use, len_raw;
    fill_t       len_use, p_inc;
    mix_t        bf [4][NLINES];
    logic signed [26:0] head_sum;
    logic signed [24:0] dry_rnd;
    logic signed [27:0] sum_rnd;
    logic signed [44:0] blend;
    logic [ADDR_W-1:0]  raddr, waddr;
    logic [SAMPLE_BITS-1:0] rdata, wdata;

    assign wl_eff    = (wet_reg > 17'(Q16_ONE)) ? 17'(Q16_ONE) : wet_reg;
    assign dc_eff    = (dampc_reg > 17'(Q16_ONE)) ? 17'(Q16_ONE) : dampc_reg;
    assign one_minus = 17'(Q16_ONE) - wl_eff;
    assign bypass    = (wl_eff < 17'(BYPASS_BELOW));
    assign accept    = samples.valid && samples.ready;

    // Pointer and fill table share one read index
    assign sel_line = (state_reg == ST_READ) ? cnt_reg : wr.line;
    assign ptr_sel  = ptr_reg[sel_line];
    assign fill_sel = fill_reg[sel_line];

    always_comb
    begin
        gain_raw = cnt_reg[2] ? gain_hi_reg[16*cnt_reg[1:0] +: 16]
                              : gain_lo_reg[16*cnt_reg[1:0] +: 16];
        gain_use = (gain_raw > 16'(GAIN_CEIL)) ? 16'(GAIN_CEIL) : gain_raw;
        len_raw  = wr.line[2] ? len_hi_reg[16*wr.line[1:0] +: 16]
                              : len_lo_reg[16*wr.line[1:0] +: 16];
        if (len_raw == 16'd0)
            len_use = 13'd1;
        else if (len_raw > 16'(LINE_DEPTH))
            len_use = 13'(LINE_DEPTH);
        else
            len_use = len_raw[FILL_W-1:0];
        p_inc = {1'b0, ptr_sel} + 13'd1;
    end

    // Hadamard butterfly over the eight heads
    always_comb
    begin
        for (int i = 0; i < NLINES; i++)
        begin
            bf[0][i] = 27'(head_reg[i]);
        end
        for (int s = 0; s < 3; s++)
        begin
            for (int i = 0; i < NLINES; i++)
            begin
                if ((i & (1 << s)) == 0)
                    bf[s+1][i] = bf[s][i] + bf[s][i + (1 << s)];
                else
                    bf[s+1][i] = bf[s][i - (1 << s)] - bf[s][i];
            end
        end
        // row zero of the butterfly is the plain sum of the heads
        head_sum = bf[3][0];
        dry_rnd = 25'(dry_reg) + 25'sd2;
        sum_rnd = 28'(head_sum) + 28'sd4;
        blend   = 45'(prod_a_reg) + wet_val_reg * $signed({1'b0, wl_eff}) + 45'sd32768;
    end

    always_comb
    begin
        state_next    = state_reg;
        samples.ready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                    state_next = bypass ? ST_DONE : ST_READ;
            end
            ST_READ:
            begin
                if (cnt_reg == line_t'(NLINES - 1))
                    state_next = ST_LAST;
            end
            ST_LAST:  state_next = ST_MIX;
            ST_MIX:   state_next = ST_FEED;
            ST_FEED:
            begin
                if (cnt_reg == line_t'(NLINES - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (wr.valid && wr.line == line_t'(NLINES - 1))
                    state_next = ST_BLEND;
            end
            ST_BLEND: state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || results.ready)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            wet_reg       <= '0;
            dampc_reg     <= 17'(Q16_ONE);
            gain_lo_reg   <= '0;
            gain_hi_reg   <= '0;
            len_lo_reg    <= LEN_RESET;
            len_hi_reg    <= LEN_RESET;
            for (int i = 0; i < NLINES; i++)
            begin
                ptr_reg[i]  <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_READ);
            if (state_reg == ST_READ || state_reg == ST_FEED)
                cnt_reg <= cnt_reg + 3'd1;
            else
                cnt_reg <= '0;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WET:     wet_reg     <= cfg_data[16:0];
                    CFG_DAMP:    dampc_reg   <= cfg_data[16:0];
                    CFG_GAIN_LO: gain_lo_reg <= cfg_data;
                    CFG_GAIN_HI: gain_hi_reg <= cfg_data;
                    CFG_LEN_LO:  len_lo_reg  <= cfg_data;
                    CFG_LEN_HI:  len_hi_reg  <= cfg_data;
                    default:     ;
                endcase
            end

            if (accept && samples.restart)
            begin
                for (int i = 0; i < NLINES; i++)
                begin
                    ptr_reg[i]  <= '0;
                    fill_reg[i] <= '0;
                end
            end
            else if (wr.valid)
            begin
                ptr_reg[wr.line] <= (p_inc >= len_use) ? '0 : p_inc[PTR_W-1:0];
                // written entries stay contiguous from zero
                if (p_inc > fill_sel)
                    fill_reg[wr.line] <= p_inc;
            end

            if (results.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_DONE && (!out_valid_reg || results.ready))
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_line_reg <= cnt_reg;
        rd_hit_reg  <= ({1'b0, ptr_sel} < fill_sel);
        if (accept)
        begin
            dry_reg    <= samples.dry_sample;
            result_reg <= samples.dry_sample;
        end
        if (rd_pend_reg)
            head_reg[rd_line_reg] <= rd_hit_reg ? $signed(rdata) : '0;
        if (state_reg == ST_MIX)
        begin
            for (int i = 0; i < NLINES; i++)
            begin
                mix_reg[i] <= bf[3][i];
            end
            quarter_reg <= dry_rnd[24:2];
            wet_val_reg <= sum_rnd[27:3];
            prod_a_reg  <= dry_reg * $signed({1'b0, one_minus});
        end
        if (state_reg == ST_BLEND)
            result_reg <= sat32(32'($signed(blend[44:16])));
        if (state_reg == ST_DONE && (!out_valid_reg || results.ready))
            out_data_reg <= result_reg;
    end

    assign raddr = {cnt_reg, ptr_sel};
    assign waddr = {wr.line, ptr_sel};
    assign wdata = sat32(32'(quarter_reg) + 32'(wr.fb));

    fdn_delay_ram #(
        .DEPTH (NLINES * LINE_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (wr.valid),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    fdn_feedback_pipe u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (accept && samples.restart),
        .in_valid (state_reg == ST_FEED),
        .in_line  (cnt_reg),
        .in_mix   (mix_reg[cnt_reg]),
        .in_gain  (gain_use),
        .dc       (dc_eff),
        .wr       (wr)
    );

    assign results.valid        = out_valid_reg;
    assign results.mixed_sample = out_data_reg;

endmodule

`default_nettype wire
